/* hdl/joystick_differential_drive_mixer_macros.svh */
// Assertion macros used by the RTL of the drive mixer.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define JDDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define JDDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/jddm_pkg.sv */
package jddm_pkg;

   typedef logic signed [31:0] q_type;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_BWD  = 2'd1,
      DIR_FWD  = 2'd2
   } dir_type;

   localparam logic [1:0] CSR_DEAD_LOW  = 2'd0;
   localparam logic [1:0] CSR_DEAD_HIGH = 2'd1;
   localparam logic [1:0] CSR_MOTOR_TOP = 2'd2;

   localparam logic [9:0]  DeadLowReset  = 10'd470;
   localparam logic [9:0]  DeadHighReset = 10'd550;
   localparam logic [11:0] MotorTopReset = 12'd3999;

   // Q16 coefficients and offsets.
   localparam q_type KFwd    = 32'sd554434;
   localparam q_type KBwd    = 32'sd557619;
   localparam q_type FwdOffQ = 32'sd304742400;
   localparam q_type BwdOffQ = 32'sd262078464;

   localparam logic [25:0] KPan     = 26'd25237;
   localparam logic [25:0] KTilt    = 26'd25303;
   localparam logic [25:0] PanOffQ  = 26'd34996224;
   localparam logic [25:0] TiltOffQ = 26'd9175040;

endpackage

/* hdl/joystick_differential_drive_mixer.sv */
// Arcade-drive mixer for a two-motor car with a pan/tilt head. Each byte taken on the req
// channel is scaled by four and stored in the next of four axis slots (drive x, drive y,
// pan, tilt, round robin from drive x after reset); every word then yields one rsp word with
// both motor duties and directions and both servo compare values. One word is accepted per
// clock while rsp_tready keeps results flowing; its result is computed in the single stage
// between the axis registers and the result register. The result register lets the next word
// enter while a result still waits. The user must write the deadband and motor top on the
// csr port only while no word is in flight; the block itself does not enforce it.
`include "joystick_differential_drive_mixer_macros.svh"

module joystick_differential_drive_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // left_duty[11:0], right_duty[23:12], left_dir[25:24],
                                    // right_dir[27:26], pan_duty[37:28], tilt_duty[47:38]
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   logic [9:0]  dead_low_ff;
   logic [9:0]  dead_high_ff;
   logic [11:0] motor_top_ff;

   logic [1:0]  slot_ff;
   logic [9:0]  axis_ff [4];
   logic        mid_valid_ff;

   jddm_pkg::dir_type held_dir_ff [2];
   jddm_pkg::dir_type held_dir_in [2];
   logic [11:0]       held_duty_ff [2];
   logic [11:0]       held_duty_in [2];

   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;
   logic [47:0] rsp_data_in;

   logic req_accept;
   logic mid_adv;

   logic [9:0] x;
   logic [9:0] y;
   logic       x_hi, x_lo, y_hi, y_lo, x_dead, y_dead;
   jddm_pkg::q_type fx, bx, fy, by;
   logic [25:0] pan_q;
   logic [25:0] tilt_q;

   function automatic logic [11:0] duty_of(input jddm_pkg::q_type q, input logic [11:0] top);
      logic [15:0] t;
      begin
         t = q[31:16];
         if (q[31]) begin
            duty_of = 12'd0;
         end else if (t > {4'd0, top}) begin
            duty_of = top;
         end else begin
            duty_of = t[11:0];
         end
      end
   endfunction

   assign mid_adv    = mid_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !mid_valid_ff || mid_adv;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_low_ff  <= jddm_pkg::DeadLowReset;
         dead_high_ff <= jddm_pkg::DeadHighReset;
         motor_top_ff <= jddm_pkg::MotorTopReset;
      end else if (csr_wen) begin
         case (csr_index)
            jddm_pkg::CSR_DEAD_LOW: begin
               dead_low_ff <= csr_wdata[9:0];
            end
            jddm_pkg::CSR_DEAD_HIGH: begin
               dead_high_ff <= csr_wdata[9:0];
            end
            jddm_pkg::CSR_MOTOR_TOP: begin
               motor_top_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= 2'd0;
         mid_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            axis_ff[i] <= 10'd0;
         end
      end else begin
         if (req_accept) begin
            axis_ff[slot_ff] <= {req_tdata, 2'b00};
            slot_ff          <= slot_ff + 2'd1;
            mid_valid_ff     <= 1'b1;
         end else if (mid_adv) begin
            mid_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      x      = axis_ff[0];
      y      = axis_ff[1];
      x_hi   = x > dead_high_ff;
      x_lo   = x < dead_low_ff;
      y_hi   = y > dead_high_ff;
      y_lo   = y < dead_low_ff;
      x_dead = !x_hi && !x_lo;
      y_dead = !y_hi && !y_lo;

      fx = jddm_pkg::KFwd * jddm_pkg::q_type'({22'd0, x}) - jddm_pkg::FwdOffQ;
      fy = jddm_pkg::KFwd * jddm_pkg::q_type'({22'd0, y}) - jddm_pkg::FwdOffQ;
      bx = jddm_pkg::BwdOffQ - jddm_pkg::KBwd * jddm_pkg::q_type'({22'd0, x});
      by = jddm_pkg::BwdOffQ - jddm_pkg::KBwd * jddm_pkg::q_type'({22'd0, y});

      held_dir_in[0]  = held_dir_ff[0];
      held_dir_in[1]  = held_dir_ff[1];
      held_duty_in[0] = held_duty_ff[0];
      held_duty_in[1] = held_duty_ff[1];

      // With an inverted deadband several rules can match; the last one wins.
      if (y_dead && x_dead) begin
         held_duty_in[0] = 12'd0;
         held_duty_in[1] = 12'd0;
      end
      if (y_dead && x_hi) begin
         held_dir_in[0]  = jddm_pkg::DIR_FWD;
         held_dir_in[1]  = jddm_pkg::DIR_BWD;
         held_duty_in[0] = duty_of(fx, motor_top_ff);
         held_duty_in[1] = duty_of(fx, motor_top_ff);
      end
      if (y_dead && x_lo) begin
         held_dir_in[0]  = jddm_pkg::DIR_BWD;
         held_dir_in[1]  = jddm_pkg::DIR_FWD;
         held_duty_in[0] = duty_of(bx, motor_top_ff);
         held_duty_in[1] = duty_of(bx, motor_top_ff);
      end
      if (y_hi && x_dead) begin
         held_dir_in[0]  = jddm_pkg::DIR_FWD;
         held_dir_in[1]  = jddm_pkg::DIR_FWD;
         held_duty_in[0] = duty_of(fy, motor_top_ff);
         held_duty_in[1] = duty_of(fy, motor_top_ff);
      end
      if (y_lo && x_dead) begin
         held_dir_in[0]  = jddm_pkg::DIR_BWD;
         held_dir_in[1]  = jddm_pkg::DIR_BWD;
         held_duty_in[0] = duty_of(by, motor_top_ff);
         held_duty_in[1] = duty_of(by, motor_top_ff);
      end
      if (y_hi && x_hi) begin
         held_dir_in[0]  = jddm_pkg::DIR_FWD;
         held_dir_in[1]  = jddm_pkg::DIR_FWD;
         held_duty_in[0] = duty_of(fy + fx, motor_top_ff);
         held_duty_in[1] = duty_of(fy - fx, motor_top_ff);
      end
      if (y_hi && x_lo) begin
         held_dir_in[0]  = jddm_pkg::DIR_FWD;
         held_dir_in[1]  = jddm_pkg::DIR_FWD;
         held_duty_in[0] = duty_of(fy - bx, motor_top_ff);
         held_duty_in[1] = duty_of(fy + bx, motor_top_ff);
      end

      pan_q  = jddm_pkg::PanOffQ - jddm_pkg::KPan * {16'd0, axis_ff[2]};
      tilt_q = jddm_pkg::KTilt * {16'd0, axis_ff[3]} + jddm_pkg::TiltOffQ;

      rsp_data_in = {tilt_q[25:16], pan_q[25:16], held_dir_in[1], held_dir_in[0],
                     held_duty_in[1], held_duty_in[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         held_dir_ff[0]  <= jddm_pkg::DIR_IDLE;
         held_dir_ff[1]  <= jddm_pkg::DIR_IDLE;
         held_duty_ff[0] <= 12'd0;
         held_duty_ff[1] <= 12'd0;
      end else begin
         if (mid_adv) begin
            rsp_valid_ff    <= 1'b1;
            held_dir_ff[0]  <= held_dir_in[0];
            held_dir_ff[1]  <= held_dir_in[1];
            held_duty_ff[0] <= held_duty_in[0];
            held_duty_ff[1] <= held_duty_in[1];
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mid_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `JDDM_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, mid_valid_ff,
                     "accepted word did not reach the compute stage")
   `JDDM_ASSERT_NEXT(a_stage_holds, clock, reset, mid_valid_ff && !mid_adv, mid_valid_ff,
                     "compute stage dropped a stalled word")
   `JDDM_ASSERT_NEXT(a_slot_steps, clock, reset, req_accept,
                     slot_ff == $past(slot_ff) + 2'd1, "axis slot did not advance by one")
   `JDDM_ASSERT_NOW(a_rsp_from_stage, clock, reset, $rose(rsp_valid_ff), $past(mid_adv),
                    "result word appeared without a computed word")

endmodule
